// ===== rtl/tlt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlt_pkg: shared types and constants of the timed line table
// Holds the entry layout, the operation and result codes, the sequencer
// states and the default table depth.
// ----------------------------------------------------------------------------
package tlt_pkg;

    // Default number of entries the table holds.
    localparam int TABLE_DEPTH_DEF = 16;

    // Operation codes carried by the operation field.
    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_CANCEL  = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    // Result codes carried by the result_kind field.
    typedef enum logic [2:0] {
        KIND_ACTIVE = 3'd0,
        KIND_NONE   = 3'd1,
        KIND_PUSHED = 3'd2,
        KIND_FULL   = 3'd3,
        KIND_DONE   = 3'd4
    } kind_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FINISH = 2'd2
    } state_t;

    // One stored entry, kept as a single memory word.
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] lifetime;
        logic [31:0] tag;
        logic [31:0] speaker;
        logic [7:0]  persona;
        logic [15:0] text_handle;
    } tlt_entry_t;

    localparam int ENTRY_W = $bits(tlt_entry_t);

endpackage

// ===== rtl/tlt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlt_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module tlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data word holds while the read is not enabled.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/timed_line_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_line_table: ordered table of timed entries
// Order: a push writes the table when accepted and presents its word from the
// finish state. Cancel, advance and query read the table one entry per cycle
// through one shared compare unit, unless a query's result word is held back,
// and present their final word from the finish state once every entry is read.
// Throughput: one word at a time; the input is ready only when idle.
// Reset: asynchronous, active low; empties the table and the result register.
// ----------------------------------------------------------------------------
module timed_line_table
    import tlt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Item channel
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] frame_now,
    input  logic [31:0] line_start,
    input  logic [31:0] line_lifetime,
    input  logic [31:0] line_tag,
    input  logic [31:0] line_speaker,
    input  logic [7:0]  line_persona,
    input  logic [15:0] line_text_handle,
    // Result channel
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  result_kind,
    output logic [31:0] out_start,
    output logic [31:0] out_lifetime,
    output logic [31:0] out_tag,
    output logic [31:0] out_speaker,
    output logic [7:0]  out_persona,
    output logic [15:0] out_text_handle,
    output logic        last_of_run
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    // Sequencer and table state.
    state_t         state_reg, state_next;
    op_t            op_reg, op_next;
    logic [31:0]    key_reg, key_next;
    kind_t          kind_reg, kind_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  rd_idx_reg, rd_idx_next;
    logic [CW-1:0]  wr_idx_reg, wr_idx_next;
    logic           data_vld_reg, data_vld_next;
    tlt_entry_t     pend_reg, pend_next;
    logic           pend_vld_reg, pend_vld_next;

    // Result register.
    logic           out_valid_reg, out_valid_next;
    kind_t          out_kind_reg, out_kind_next;
    tlt_entry_t     out_entry_reg, out_entry_next;
    logic           out_last_reg, out_last_next;

    // Memory port signals.
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    tlt_entry_t     ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    tlt_entry_t     cur;

    // Shared compare unit.
    logic [31:0]    end_frame;
    logic           hit;
    logic           out_free;
    logic           need_emit;
    logic           go;
    tlt_entry_t     push_entry;

    tlt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur = tlt_entry_t'(ram_rdata);

    // End frame and the operation's test on the entry just read.
    always_comb
    begin
        end_frame = cur.start + cur.lifetime;
        case (op_reg)
            OP_CANCEL:  hit = (cur.tag == key_reg);
            OP_ADVANCE: hit = (end_frame < key_reg);
            OP_QUERY:   hit = (cur.start <= key_reg) && (end_frame >= key_reg);
            default:    hit = 1'b0;
        endcase
    end

    assign out_free   = !out_valid_reg || result_ready;
    assign need_emit  = (state_reg == ST_SCAN) && data_vld_reg && (op_reg == OP_QUERY)
                        && hit && pend_vld_reg;
    assign go         = !(need_emit && !out_free);
    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        push_entry.start       = line_start;
        push_entry.lifetime    = line_lifetime;
        push_entry.tag         = line_tag;
        push_entry.speaker     = line_speaker;
        push_entry.persona     = line_persona;
        push_entry.text_handle = line_text_handle;
    end

    // Sequencer: next state, memory control and result loading.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        kind_next      = kind_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        data_vld_next  = data_vld_reg;
        pend_next      = pend_reg;
        pend_vld_next  = pend_vld_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_kind_next  = out_kind_reg;
        out_entry_next = out_entry_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_idx_reg[AW-1:0];
        ram_wdata      = cur;
        ram_re         = 1'b0;
        ram_raddr      = rd_idx_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    op_next       = op_t'(operation);
                    key_next      = (op_t'(operation) == OP_CANCEL) ? line_tag : frame_now;
                    rd_idx_next   = '0;
                    wr_idx_next   = '0;
                    data_vld_next = 1'b0;
                    pend_vld_next = 1'b0;
                    if (op_t'(operation) == OP_PUSH)
                    begin
                        state_next = ST_FINISH;
                        if (count_reg == FULL_COUNT)
                        begin
                            kind_next = KIND_FULL;
                        end
                        else
                        begin
                            kind_next  = KIND_PUSHED;
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            ram_wdata  = push_entry;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                        kind_next  = (op_t'(operation) == OP_QUERY) ? KIND_NONE : KIND_DONE;
                    end
                end
            end

            ST_SCAN:
            begin
                if (!data_vld_reg && (rd_idx_reg == count_reg))
                begin
                    // Every entry has been seen.
                    state_next = ST_FINISH;
                    if (op_reg != OP_QUERY)
                    begin
                        count_next = wr_idx_reg;
                    end
                end
                else if (go)
                begin
                    // Fetch the next entry.
                    ram_re        = 1'b1;
                    data_vld_next = (rd_idx_reg < count_reg);
                    if (rd_idx_reg < count_reg)
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                    // Work on the entry fetched by the previous read.
                    if (data_vld_reg)
                    begin
                        if (op_reg == OP_QUERY)
                        begin
                            if (hit)
                            begin
                                if (pend_vld_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_kind_next  = KIND_ACTIVE;
                                    out_entry_next = pend_reg;
                                    out_last_next  = 1'b0;
                                end
                                pend_next     = cur;
                                pend_vld_next = 1'b1;
                            end
                        end
                        else if (!hit)
                        begin
                            ram_we      = 1'b1;
                            wr_idx_next = wr_idx_reg + 1'b1;
                        end
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if ((op_reg == OP_QUERY) && pend_vld_reg)
                    begin
                        out_kind_next  = KIND_ACTIVE;
                        out_entry_next = pend_reg;
                    end
                    else
                    begin
                        out_kind_next  = kind_reg;
                        out_entry_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            data_vld_reg  <= 1'b0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_PUSH;
            kind_reg      <= KIND_DONE;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            data_vld_reg  <= data_vld_next;
            pend_vld_reg  <= pend_vld_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            kind_reg      <= kind_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        pend_reg      <= pend_next;
        out_kind_reg  <= out_kind_next;
        out_entry_reg <= out_entry_next;
        out_last_reg  <= out_last_next;
    end

    // Result ports.
    assign result_valid    = out_valid_reg;
    assign result_kind     = out_kind_reg;
    assign out_start       = out_entry_reg.start;
    assign out_lifetime    = out_entry_reg.lifetime;
    assign out_tag         = out_entry_reg.tag;
    assign out_speaker     = out_entry_reg.speaker;
    assign out_persona     = out_entry_reg.persona;
    assign out_text_handle = out_entry_reg.text_handle;
    assign last_of_run     = out_last_reg;

`ifndef SYNTHESIS
    // The table never holds more entries than it has room for.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
    else $error("entry count exceeds table depth");

    // During a scan, compaction never writes ahead of the entries already read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |->
        ((wr_idx_reg <= rd_idx_reg) && (rd_idx_reg <= count_reg)))
    else $error("scan indexes out of order");

    // A push into a full table leaves the entry count unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && (operation == OP_PUSH) && (count_reg == FULL_COUNT))
        |=> $stable(count_reg))
    else $error("push into full table changed the count");

    // A scan holds its entry count until it finishes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && $past(state_reg == ST_SCAN) |-> $stable(count_reg))
    else $error("entry count changed during a scan");
`endif

endmodule

// ===== bench/timed_line_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_line_table_checker: result predictor and comparator
// Watches both channels of the timed line table. Every accepted input word
// is applied to a private copy of the table, and the result words it should
// cause are queued. Every accepted result word is compared field by field
// with the oldest queued word.
// ----------------------------------------------------------------------------
module timed_line_table_checker
    import tlt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] frame_now,
    input  logic [31:0] line_start,
    input  logic [31:0] line_lifetime,
    input  logic [31:0] line_tag,
    input  logic [31:0] line_speaker,
    input  logic [7:0]  line_persona,
    input  logic [15:0] line_text_handle,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [2:0]  result_kind,
    input  logic [31:0] out_start,
    input  logic [31:0] out_lifetime,
    input  logic [31:0] out_tag,
    input  logic [31:0] out_speaker,
    input  logic [7:0]  out_persona,
    input  logic [15:0] out_text_handle,
    input  logic        last_of_run,
    output int          mismatch_count,
    output int          words_pending
);

    // One result word as the block should present it.
    typedef struct packed {
        kind_t      kind;
        tlt_entry_t entry;
        logic       last;
    } result_word_t;

    tlt_entry_t   table_entries [TABLE_DEPTH];
    int           entry_total = 0;
    result_word_t expected_words [$];
    int           fail_total = 0;

    // End frame of an entry, wrapping modulo 2^32.
    function automatic logic [31:0] end_frame(tlt_entry_t e);
        logic [31:0] sum;
        sum = e.start + e.lifetime;
        return sum;
    endfunction

    task automatic queue_word(kind_t kind, tlt_entry_t entry, logic last);
        result_word_t w;
        w.kind  = kind;
        w.entry = entry;
        w.last  = last;
        expected_words = {expected_words, w};
    endtask

    // Apply one operation to the table copy and queue the words it causes.
    task automatic predict_table_op(op_t op, logic [31:0] frame, tlt_entry_t incoming);
        tlt_entry_t blank;
        int         keep;
        int         last_hit;
        logic       hit;
        blank    = '0;
        keep     = 0;
        last_hit = -1;
        case (op)
            OP_PUSH:
            begin
                if (entry_total >= TABLE_DEPTH)
                begin
                    queue_word(KIND_FULL, blank, 1'b1);
                end
                else
                begin
                    table_entries[entry_total] = incoming;
                    entry_total++;
                    queue_word(KIND_PUSHED, blank, 1'b1);
                end
            end
            OP_CANCEL, OP_ADVANCE:
            begin
                // Compact the table, keeping the order of the survivors.
                for (int r = 0; r < entry_total; r++)
                begin
                    if (op == OP_CANCEL)
                        hit = (table_entries[r].tag == incoming.tag);
                    else
                        hit = (end_frame(table_entries[r]) < frame);
                    if (!hit)
                    begin
                        table_entries[keep] = table_entries[r];
                        keep++;
                    end
                end
                entry_total = keep;
                queue_word(KIND_DONE, blank, 1'b1);
            end
            default:
            begin
                // Find the final active entry first so it can carry the last flag.
                for (int r = 0; r < entry_total; r++)
                begin
                    if (table_entries[r].start <= frame && end_frame(table_entries[r]) >= frame)
                        last_hit = r;
                end
                if (last_hit < 0)
                begin
                    queue_word(KIND_NONE, blank, 1'b1);
                end
                else
                begin
                    for (int r = 0; r <= last_hit; r++)
                    begin
                        if (table_entries[r].start <= frame
                            && end_frame(table_entries[r]) >= frame)
                            queue_word(KIND_ACTIVE, table_entries[r], r == last_hit);
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_total++;
        end
    endtask

    // Result side first: its words always belong to older input words.
    always @(posedge clk)
    begin
        result_word_t want;
        tlt_entry_t   incoming;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word of kind %0d arrived with nothing expected",
                           result_kind);
                    fail_total++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(result_kind));
                    check_field("out_start", want.entry.start, out_start);
                    check_field("out_lifetime", want.entry.lifetime, out_lifetime);
                    check_field("out_tag", want.entry.tag, out_tag);
                    check_field("out_speaker", want.entry.speaker, out_speaker);
                    check_field("out_persona", 32'(want.entry.persona), 32'(out_persona));
                    check_field("out_text_handle", 32'(want.entry.text_handle),
                                32'(out_text_handle));
                    check_field("last_of_run", 32'(want.last), 32'(last_of_run));
                end
            end
            if (item_valid && item_ready)
            begin
                incoming.start       = line_start;
                incoming.lifetime    = line_lifetime;
                incoming.tag         = line_tag;
                incoming.speaker     = line_speaker;
                incoming.persona     = line_persona;
                incoming.text_handle = line_text_handle;
                predict_table_op(op_t'(operation), frame_now, incoming);
            end
            mismatch_count <= fail_total;
            words_pending  <= expected_words.size();
        end
    end

endmodule

// ===== bench/tb_timed_line_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_line_table: testbench top of the timed line table
// Drives a directed opening (empty table, field extremes, wrapping end
// frames, a full table) and then random operation words around moving frame
// windows, under three idling patterns and one long result stall. A checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_timed_line_table
    import tlt_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 40;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic [1:0]  operation;
    logic [31:0] frame_now;
    logic [31:0] line_start;
    logic [31:0] line_lifetime;
    logic [31:0] line_tag;
    logic [31:0] line_speaker;
    logic [7:0]  line_persona;
    logic [15:0] line_text_handle;
    logic        result_valid;
    logic        result_ready;
    logic [2:0]  result_kind;
    logic [31:0] out_start;
    logic [31:0] out_lifetime;
    logic [31:0] out_tag;
    logic [31:0] out_speaker;
    logic [7:0]  out_persona;
    logic [15:0] out_text_handle;
    logic        last_of_run;
    int          mismatch_count;
    int          words_pending;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_off_request = 1'b0;
    int          hold_left = 0;
    int          cycle_count = 0;
    logic [31:0] frame_base = 32'd0;
    logic [31:0] tag_pool [6];

    timed_line_table u_dut (.*);

    timed_line_table_checker u_checker (.*);

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter and watchdog.
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        bit hold_done;
        hold_done    = 1'b0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_request && !hold_done)
            begin
                hold_left = 600;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one word and wait until it is accepted. Valid is lowered only
    // when an idle gap is taken, so it never drops between back-to-back words.
    task automatic send_word(op_t op, logic [31:0] frame, logic [31:0] start,
                             logic [31:0] life, logic [31:0] tag, logic [31:0] speaker,
                             logic [7:0] persona, logic [15:0] text);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        item_valid       <= 1'b1;
        operation        <= op;
        frame_now        <= frame;
        line_start       <= start;
        line_lifetime    <= life;
        line_tag         <= tag;
        line_speaker     <= speaker;
        line_persona     <= persona;
        line_text_handle <= text;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // A frame close to the current window, now and then anywhere.
    function automatic logic [31:0] near_base(int span);
        if ($urandom_range(99) < 8)
            return $urandom;
        return frame_base + $urandom_range(span);
    endfunction

    task automatic send_random_word();
        int          pick;
        op_t         op;
        logic [31:0] frame;
        logic [31:0] start;
        logic [31:0] life;
        logic [31:0] tag;
        pick = $urandom_range(99);
        if (pick < 40)
            op = OP_PUSH;
        else if (pick < 70)
            op = OP_QUERY;
        else if (pick < 85)
            op = OP_ADVANCE;
        else
            op = OP_CANCEL;
        start = near_base(200);
        case ($urandom_range(9))
            0:       life = $urandom;
            1:       life = 32'hFFFF_FFFF - $urandom_range(255);
            default: life = $urandom_range(300);
        endcase
        frame = (op == OP_ADVANCE) ? near_base(250) : near_base(500);
        tag   = ($urandom_range(3) == 0) ? $urandom : tag_pool[$urandom_range(5)];
        send_word(op, frame, start, life, tag, $urandom, 8'($urandom), 16'($urandom));
    endtask

    // A random phase; the frame window moves every fifty words.
    task automatic run_phase(int count, int send_pct, int recv_pct, bit with_hold_off);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
            begin
                case ($urandom_range(3))
                    0:       frame_base = 32'd0;
                    1:       frame_base = 32'hFFFF_FF00;
                    default: frame_base = $urandom;
                endcase
            end
            if (with_hold_off && n == 80)
                hold_off_request = 1'b1;
            send_random_word();
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n            = 1'b0;
        item_valid       = 1'b0;
        operation        = OP_PUSH;
        frame_now        = '0;
        line_start       = '0;
        line_lifetime    = '0;
        line_tag         = '0;
        line_speaker     = '0;
        line_persona     = '0;
        line_text_handle = '0;
        tag_pool[0] = 32'd0;
        tag_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 6; i++)
            tag_pool[i] = $urandom;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: operations on an empty table.
        send_idle_pct = 10;
        recv_idle_pct = 30;
        send_word(OP_QUERY, 32'd0, '0, '0, '0, '0, '0, '0);
        send_word(OP_ADVANCE, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0);
        send_word(OP_CANCEL, 32'd0, '0, '0, 32'd0, '0, '0, '0);
        // All-zero entry, all-ones entry, and an entry whose end wraps.
        send_word(OP_PUSH, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0, 16'd0);
        send_word(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send_word(OP_PUSH, 32'd0, 32'hFFFF_FFF0, 32'h20, 32'd7, 32'h1234_5678,
                  8'h5A, 16'hA5A5);
        send_word(OP_QUERY, 32'd0, '0, '0, '0, '0, '0, '0);
        send_word(OP_QUERY, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0);
        send_word(OP_ADVANCE, 32'd1, '0, '0, '0, '0, '0, '0);
        // Fill the table; the last push finds it full.
        for (int i = 0; i < 15; i++)
            send_word(OP_PUSH, $urandom, 32'd100 + i, 32'd50, (i % 2) ? 32'd7 : 32'd8,
                      $urandom, 8'($urandom), 16'($urandom));
        send_word(OP_QUERY, 32'd120, '0, '0, '0, '0, '0, '0);
        send_word(OP_CANCEL, 32'd0, '0, '0, 32'd7, '0, '0, '0);
        send_word(OP_ADVANCE, 32'h100, '0, '0, '0, '0, '0, '0);
        send_word(OP_CANCEL, 32'd0, '0, '0, 32'hFFFF_FFFF, '0, '0, '0);

        // Random phases under the three idling patterns.
        run_phase(145, 21, 60, 1'b1);
        run_phase(145, 60, 21, 1'b0);
        run_phase(142, 0, 0, 1'b0);
        item_valid <= 1'b0;
        @(posedge clk);

        // Drain outstanding result words, then let the block settle.
        while (words_pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && words_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
